@@ hw/rtl/windowed_sample_statistics_core_defines.svh @@
// Assertion macros shared by the windowed sample statistics RTL.
// No dependencies; included by modules that carry assertions.
`ifndef WINDOWED_SAMPLE_STATISTICS_CORE_DEFINES_SVH
`define WINDOWED_SAMPLE_STATISTICS_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define WSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define WSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/wss_pkg.sv @@
// Package for the windowed sample statistics core: types and constants.
// No dependencies.
package wss_pkg;
  localparam int unsigned MaxSamplesDefault = 65536;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    REG_WINDOW_START = 2'd0,
    REG_WINDOW_STOP  = 2'd1
  } reg_index_t;

  // Classified sample moved from front to back
  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [15:0] sample_value;
    logic               last_sample;
    logic [15:0]        index;
    logic               first_of_series;
    logic               in_window;
    logic               at_or_after_start;
    logic               at_or_before_stop;
    logic               before_stop;
    logic [31:0]        window_start;
    logic [31:0]        window_stop;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_WAIT,
    ST_DIV,
    ST_OUT
  } back_state_t;
endpackage

@@ hw/rtl/wss_front.sv @@
// Front end: accepts samples, counts indices and classifies against the window.
// Depends on wss_pkg.
module wss_front #(
  parameter int unsigned MAX_SAMPLES = wss_pkg::MaxSamplesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                s_valid,
  output logic                s_ready,
  input  logic [31:0]         s_time,
  input  logic signed [15:0]  s_value,
  input  logic                s_last,
  output logic                q_valid,
  input  logic                q_ready,
  output wss_pkg::item_t      q_item
);
  import wss_pkg::*;
  `include "windowed_sample_statistics_core_defines.svh"

  localparam logic [15:0] IndexLimit = (MAX_SAMPLES - 1 < 65535) ?
                                       16'(MAX_SAMPLES - 1) : 16'hFFFF;

  logic [31:0] window_start;
  logic [31:0] window_stop;
  logic [15:0] sample_counter;
  item_t       queue [QueueDepth];
  logic        rd_ptr, wr_ptr;
  logic [1:0]  count;
  logic        push, pop;
  item_t       cls;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_stop  <= '1;
    end else if (cfg_we) begin
      if (cfg_index == REG_WINDOW_START) window_start <= cfg_data;
      else if (cfg_index == REG_WINDOW_STOP) window_stop <= cfg_data;
    end
  end

  assign s_ready = (count != 2'(QueueDepth));
  assign push    = s_valid && s_ready;
  assign q_valid = (count != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_item  = queue[rd_ptr];

  // Classify the incoming sample
  always_comb begin
    cls.sample_time       = s_time;
    cls.sample_value      = s_value;
    cls.last_sample       = s_last;
    cls.index             = sample_counter;
    cls.first_of_series   = (sample_counter == 16'd0);
    cls.at_or_after_start = (window_start <= s_time);
    cls.at_or_before_stop = (s_time <= window_stop);
    cls.before_stop       = (s_time < window_stop);
    cls.in_window         = cls.at_or_after_start && cls.at_or_before_stop;
    cls.window_start      = window_start;
    cls.window_stop       = window_stop;
  end

  // Advance the index counter, holding at IndexLimit; restart after the last sample
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
    end else if (push) begin
      if (s_last) sample_counter <= '0;
      else if (sample_counter < IndexLimit) sample_counter <= sample_counter + 16'd1;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `WSS_ASSERT_IMPL(a_no_overflow, count == 2'(QueueDepth), !push, "queue overflow")
  `WSS_ASSERT_IMPL(a_count_range, 1'b1, count <= 2'(QueueDepth), "queue count out of range")
  `WSS_ASSERT_NEXT(a_idx_bound, push && !s_last, sample_counter <= IndexLimit,
                   "index beyond limit")
endmodule

@@ hw/rtl/wss_divider.sv @@
// Restoring divider, one quotient bit per cycle, unsigned 64 by 34 bits.
// Depends on wss_pkg.
module wss_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [33:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import wss_pkg::*;

  logic [63:0] quo;
  logic [34:0] rem;
  logic [6:0]  steps;
  logic        busy;
  logic [34:0] trial;

  assign trial    = {rem[33:0], quo[63]} - {1'b0, divisor};
  assign quotient = quo;

  // Shift one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 7'd64;
      end else if (busy) begin
        steps <= steps - 7'd1;
        if (steps == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (!trial[34]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[33:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end
  end
endmodule

@@ hw/rtl/wss_back.sv @@
// Back end: interval accumulation, extremes, first/last tracking and result.
// Depends on wss_pkg and wss_divider.
module wss_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  wss_pkg::item_t      q_item,
  output logic                m_valid,
  input  logic                m_ready,
  output logic [119:0]        m_data
);
  import wss_pkg::*;
  `include "windowed_sample_statistics_core_defines.svh"

  back_state_t state, state_next;
  item_t       it;

  logic [31:0]        held_time;
  logic signed [15:0] held_value;
  logic               held_valid;
  logic [32:0]        prev_boundary_half;
  logic [63:0]        weighted_sum;
  logic [33:0]        total_period_half;
  logic signed [15:0] ext_min, ext_max;
  logic [15:0]        ext_minmag, ext_maxmag;
  logic [15:0]        idx_min, idx_max, idx_minmag, idx_maxmag;
  logic               extreme_set;
  logic [15:0]        first_idx, last_idx;
  logic               first_flag, last_flag;
  logic               final_done;

  // Interval pipeline registers
  logic               iv1_en, iv2_en;
  logic signed [15:0] iv1_value;
  logic signed [34:0] iv1_len;
  logic signed [50:0] product;

  logic [32:0]        pb;
  logic [32:0]        nb1, nb2;
  logic               close1, close2;
  logic [16:0]        mag;

  logic               div_start, div_done;
  logic [63:0]        div_q, smag;
  logic [33:0]        pmag;
  logic               sneg, pneg;
  logic signed [15:0] avg;
  logic               avg_valid;

  logic               take;

  assign take    = q_valid && q_ready;
  assign q_ready = (state == ST_IDLE);
  assign pb      = it.first_of_series ? {it.window_start, 1'b0} : prev_boundary_half;
  assign mag     = it.sample_value[15] ? 17'(-$signed({it.sample_value[15], it.sample_value}))
                                       : 17'(it.sample_value);
  assign nb1     = it.before_stop ? 33'(held_time) + 33'(it.sample_time)
                                  : {it.window_stop, 1'b0};
  assign close1  = held_valid && !it.first_of_series;
  assign close2  = it.in_window && it.last_sample;
  assign nb2     = {it.window_stop, 1'b0};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = (close2 && !final_done) ? ST_MUL
                            : (it.last_sample ? ST_WAIT : ST_IDLE);
      ST_WAIT: if (!iv1_en && !iv2_en) state_next = ST_DIV;
      ST_DIV:  if (div_done || total_period_half == '0) state_next = ST_OUT;
      ST_OUT:  if (m_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs; start the divider once the sum has settled and the period is nonzero
  always_comb begin
    m_valid   = (state == ST_OUT);
    div_start = (state == ST_WAIT) && !iv1_en && !iv2_en
                && (total_period_half != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (take) it <= q_item;
  end

  // Multiply: weight one interval
  always_ff @(posedge clk) begin
    if (rst) begin
      iv2_en <= 1'b0;
    end else begin
      iv2_en <= iv1_en;
    end
    product <= 51'(iv1_value) * 51'(iv1_len);
  end

  // Accumulate and update series state
  always_ff @(posedge clk) begin
    if (rst) begin
      iv1_en             <= 1'b0;
      held_valid         <= 1'b0;
      prev_boundary_half <= '0;
      weighted_sum       <= '0;
      total_period_half  <= '0;
      extreme_set        <= 1'b0;
      first_flag         <= 1'b0;
      last_flag          <= 1'b0;
      held_time          <= '0;
      held_value         <= '0;
      first_idx          <= '0;
      last_idx           <= '0;
      final_done         <= 1'b0;
    end else begin
      iv1_en <= 1'b0;
      if (take) final_done <= 1'b0;
      if (iv2_en) begin
        weighted_sum <= weighted_sum + 64'(product);
      end
      // Close the held interval, else the final one; the final follows in a second pass
      if (state == ST_MUL) begin
        if (close1) begin
          iv1_en             <= 1'b1;
          iv1_value          <= held_value;
          iv1_len            <= 35'($signed({2'b00, nb1})) - 35'($signed({2'b00, pb}));
          total_period_half  <= total_period_half + 34'(nb1) - 34'(pb);
          prev_boundary_half <= nb1;
          held_valid         <= 1'b0;
        end else if (close2 && !final_done) begin
          iv1_en             <= 1'b1;
          iv1_value          <= it.sample_value;
          iv1_len            <= 35'($signed({2'b00, nb2})) - 35'($signed({2'b00, pb}));
          total_period_half  <= total_period_half + 34'(nb2) - 34'(pb);
          prev_boundary_half <= nb2;
          final_done         <= 1'b1;
        end else if (it.first_of_series) begin
          prev_boundary_half <= pb;
          held_valid         <= 1'b0;
        end
      end
      if (state == ST_ACC) begin
        if (!first_flag && it.at_or_after_start) begin
          first_idx  <= it.index;
          first_flag <= 1'b1;
        end
        if (it.at_or_before_stop) begin
          last_idx  <= it.index;
          last_flag <= 1'b1;
        end
        if (it.in_window) begin
          if (!extreme_set || it.sample_value < ext_min) begin
            ext_min <= it.sample_value; idx_min <= it.index;
          end
          if (!extreme_set || it.sample_value > ext_max) begin
            ext_max <= it.sample_value; idx_max <= it.index;
          end
          if (!extreme_set || 16'(mag) < ext_minmag) begin
            ext_minmag <= 16'(mag); idx_minmag <= it.index;
          end
          if (!extreme_set || 16'(mag) > ext_maxmag) begin
            ext_maxmag <= 16'(mag); idx_maxmag <= it.index;
          end
          extreme_set <= 1'b1;
          if (!it.last_sample) begin
            held_time  <= it.sample_time;
            held_value <= it.sample_value;
            held_valid <= 1'b1;
          end
        end
      end
      // Clear the series once the result has been transferred
      if (state == ST_OUT && m_ready) begin
        held_valid        <= 1'b0;
        weighted_sum      <= '0;
        total_period_half <= '0;
        extreme_set       <= 1'b0;
        first_flag        <= 1'b0;
        last_flag         <= 1'b0;
        first_idx         <= '0;
        last_idx          <= '0;
      end
    end
  end

  // Signed magnitudes for the divider
  assign sneg = weighted_sum[63];
  assign smag = sneg ? (~weighted_sum + 64'd1) : weighted_sum;
  assign pneg = total_period_half[33];
  assign pmag = pneg ? (~total_period_half + 34'd1) : total_period_half;

  wss_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (smag),
    .divisor  (pmag),
    .done     (div_done),
    .quotient (div_q)
  );

  // Apply the sign and saturate the quotient; zero and invalid when the period is zero
  always_ff @(posedge clk) begin
    if (state == ST_DIV) begin
      if (total_period_half == '0) begin
        avg       <= '0;
        avg_valid <= 1'b0;
      end else if (div_done) begin
        avg_valid <= 1'b1;
        if (sneg != pneg) avg <= (div_q > 64'd32768) ? 16'sh8000 : 16'(64'd0 - div_q);
        else              avg <= (div_q > 64'd32767) ? 16'sh7FFF : 16'(div_q);
      end
    end
  end

  // Result fields from bit 0 up
  assign m_data = {4'd0,
                   last_flag, last_flag ? last_idx : 16'd0,
                   first_flag, first_flag ? first_idx : 16'd0,
                   avg_valid, avg,
                   extreme_set ? idx_maxmag : 16'd0,
                   extreme_set ? idx_minmag : 16'd0,
                   extreme_set ? idx_max : 16'd0,
                   extreme_set ? idx_min : 16'd0,
                   extreme_set};

  `WSS_ASSERT_IMPL(a_ready_idle, q_ready, state == ST_IDLE, "ready outside idle")
  `WSS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data),
                   "result dropped")
  `WSS_ASSERT_IMPL(a_div_nonzero, div_start, pmag != '0, "divide by zero")
endmodule

@@ hw/rtl/windowed_sample_statistics_core.sv @@
// Top level: front end with a two-entry queue feeding the back end (wss_pkg, wss_front, wss_back).
// The back end takes one sample at a time through idle, multiply and accumulate, with a
// second multiply and accumulate pass when a final sample also closes a held interval;
// it accepts no new sample until it is back in idle. The 64-step divider runs once per
// series with a nonzero period; a zero period skips the division.
// Reset (rst, synchronous): window_start 0, window_stop all ones, series cleared.
module windowed_sample_statistics_core #(
  parameter int unsigned MAX_SAMPLES = wss_pkg::MaxSamplesDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // sample_time[31:0], sample_value[47:32]
  input  logic         s_axis_tlast,  // last_sample
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // any_in_window, min_index, max_index, min_mag_index, max_mag_index, average,
  // average_valid, first_index, first_found, last_index, last_found, zero fill
  output logic [119:0] m_axis_tdata
);
  import wss_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;

  wss_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_time    (s_axis_tdata[31:0]),
    .s_value   (s_axis_tdata[47:32]),
    .s_last    (s_axis_tlast),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  wss_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata)
  );
endmodule

@@ tb/windowed_sample_statistics_core_test.sv @@
// Self-checking bench for windowed_sample_statistics_core: sample stream in,
// one statistics record out per series. Depends on wss_pkg and the core RTL.
module windowed_sample_statistics_core_test;
  import wss_pkg::*;

  localparam logic [1:0] RegSpareA = 2'd2;
  localparam logic [1:0] RegSpareB = 2'd3;
  localparam int unsigned IndexCap = 65535;
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned RandomItems = 1000;

  typedef struct packed {
    logic        any_in_window;
    logic [15:0] min_index;
    logic [15:0] max_index;
    logic [15:0] min_mag_index;
    logic [15:0] max_mag_index;
    logic [15:0] average;
    logic        average_valid;
    logic [15:0] first_index;
    logic        first_found;
    logic [15:0] last_index;
    logic        last_found;
  } stats_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] data;
    logic [15:0] value;
    logic        last;
    logic        typed;
    stats_t      result;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;

  windowed_sample_statistics_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the window registers and the series state
  logic [31:0] win_start, win_stop;
  int unsigned sample_idx;
  logic [31:0] held_t;
  int held_v;
  bit held_ok;
  longint prev_half;
  logic [63:0] wsum;
  longint period_half;
  int ext_val[4];
  int unsigned ext_idx[4];
  bit ext_ok;
  int unsigned edge_idx[2];
  bit edge_ok[2];

  stats_t stats_due[$];
  int errors = 0;
  int n_samples = 0;
  int n_records = 0;
  int n_writes = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  function automatic void clear_series();
    sample_idx = 0;
    held_t = '0;
    held_v = 0;
    held_ok = 1'b0;
    prev_half = 2 * longint'(win_start);
    wsum = '0;
    period_half = 0;
    for (int i = 0; i < 4; i++) begin
      ext_val[i] = 0;
      ext_idx[i] = 0;
    end
    ext_ok = 1'b0;
    edge_idx = '{0, 0};
    edge_ok = '{1'b0, 1'b0};
  endfunction

  function automatic void close_span(int v, longint next_half);
    longint span;
    span = next_half - prev_half;
    wsum += 64'(longint'(v) * span);
    period_half += span;
    prev_half = next_half;
  endfunction

  function automatic void average_of(output logic [15:0] avg, output logic ok);
    logic [63:0] smag, pmag, q;
    bit sneg, pneg;
    avg = '0;
    ok = 1'b0;
    if (period_half != 0) begin
      ok = 1'b1;
      sneg = wsum[63];
      smag = sneg ? -wsum : wsum;
      pneg = period_half < 0;
      pmag = pneg ? 64'(-period_half) : 64'(period_half);
      q = smag / pmag;
      if (sneg != pneg) begin
        if (q > 64'd32768) q = 64'd32768;
        avg = 16'(-q);
      end else begin
        if (q > 64'd32767) q = 64'd32767;
        avg = q[15:0];
      end
    end
  endfunction

  // Advance the shadow by one sample; return 1 with the record on the last one
  function automatic bit track_sample(logic [31:0] t, logic [15:0] vb, logic last,
                                      output stats_t r);
    int v, mag;
    int unsigned idx;
    bit inwin;
    longint stop_half;
    v = int'($signed(vb));
    mag = v < 0 ? -v : v;
    idx = sample_idx;
    inwin = win_start <= t && t <= win_stop;
    stop_half = 2 * longint'(win_stop);
    r = '0;
    if (idx == 0) prev_half = 2 * longint'(win_start);
    if (held_ok) begin
      close_span(held_v, t < win_stop ? longint'(held_t) + longint'(t) : stop_half);
      held_ok = 1'b0;
    end
    if (!edge_ok[0] && win_start <= t) begin
      edge_idx[0] = idx;
      edge_ok[0] = 1'b1;
    end
    if (t <= win_stop) begin
      edge_idx[1] = idx;
      edge_ok[1] = 1'b1;
    end
    if (inwin) begin
      if (!ext_ok || v < ext_val[0]) begin ext_val[0] = v; ext_idx[0] = idx; end
      if (!ext_ok || v > ext_val[1]) begin ext_val[1] = v; ext_idx[1] = idx; end
      if (!ext_ok || mag < ext_val[2]) begin ext_val[2] = mag; ext_idx[2] = idx; end
      if (!ext_ok || mag > ext_val[3]) begin ext_val[3] = mag; ext_idx[3] = idx; end
      ext_ok = 1'b1;
      if (last) begin
        close_span(v, stop_half);
      end else begin
        held_t = t;
        held_v = v;
        held_ok = 1'b1;
      end
    end
    if (sample_idx < IndexCap) sample_idx++;
    if (!last) return 1'b0;
    average_of(r.average, r.average_valid);
    r.any_in_window = ext_ok;
    if (ext_ok) begin
      r.min_index = 16'(ext_idx[0]);
      r.max_index = 16'(ext_idx[1]);
      r.min_mag_index = 16'(ext_idx[2]);
      r.max_mag_index = 16'(ext_idx[3]);
    end
    r.first_found = edge_ok[0];
    r.first_index = edge_ok[0] ? 16'(edge_idx[0]) : 16'd0;
    r.last_found = edge_ok[1];
    r.last_index = edge_ok[1] ? 16'(edge_idx[1]) : 16'd0;
    clear_series();
    return 1'b1;
  endfunction

  // Offer one sample and hold it until the transfer; typed overrides the prediction
  task automatic send_sample(logic [31:0] t, logic [15:0] v, logic last,
                             bit typed = 1'b0, stats_t typed_rec = '0);
    int gap;
    stats_t rec;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {v, t};
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    n_samples++;
    if (track_sample(t, v, last, rec)) stats_due.push_back(typed ? typed_rec : rec);
  endtask

  // Write a register once the core has drained
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    s_axis_tvalid <= 1'b0;
    wait (stats_due.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_writes++;
    if (idx == REG_WINDOW_START) win_start = data;
    else if (idx == REG_WINDOW_STOP) win_stop = data;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Pick a new window: default, narrow, inverted, extreme or a spare index
  task automatic rewindow();
    logic [31:0] a;
    a = $urandom;
    case ($urandom_range(0, 4))
      0: begin
        write_reg(REG_WINDOW_START, 32'd0);
        write_reg(REG_WINDOW_STOP, 32'hFFFF_FFFF);
      end
      1: begin
        write_reg(REG_WINDOW_START, a);
        write_reg(REG_WINDOW_STOP, a + $urandom_range(0, 300));
      end
      2: begin
        write_reg(REG_WINDOW_START, a);
        write_reg(REG_WINDOW_STOP, a - $urandom_range(1, 100));
      end
      3: begin
        a = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        write_reg(REG_WINDOW_START, a);
        write_reg(REG_WINDOW_STOP, a);
      end
      default: write_reg($urandom_range(0, 1) ? RegSpareA : RegSpareB, a);
    endcase
  endtask

  // Result side: random stalls, one long hold on request
  initial begin
    int stall;
    stats_t got, want;
    forever begin
      if (hold_req) begin
        stall = 400;
        hold_req = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && !rst));
      got = '0;
      got.any_in_window = m_axis_tdata[0];
      got.min_index = m_axis_tdata[16:1];
      got.max_index = m_axis_tdata[32:17];
      got.min_mag_index = m_axis_tdata[48:33];
      got.max_mag_index = m_axis_tdata[64:49];
      got.average = m_axis_tdata[80:65];
      got.average_valid = m_axis_tdata[81];
      got.first_index = m_axis_tdata[97:82];
      got.first_found = m_axis_tdata[98];
      got.last_index = m_axis_tdata[114:99];
      got.last_found = m_axis_tdata[115];
      n_records++;
      if (stats_due.size() == 0) begin
        $error("record transferred with none expected");
        errors++;
      end else begin
        want = stats_due.pop_front();
        if (got.any_in_window !== want.any_in_window) begin
          $error("any_in_window: expected %0d, got %0d", want.any_in_window, got.any_in_window);
          errors++;
        end
        if (got.min_index !== want.min_index) begin
          $error("min_index: expected %0d, got %0d", want.min_index, got.min_index);
          errors++;
        end
        if (got.max_index !== want.max_index) begin
          $error("max_index: expected %0d, got %0d", want.max_index, got.max_index);
          errors++;
        end
        if (got.min_mag_index !== want.min_mag_index) begin
          $error("min_mag_index: expected %0d, got %0d", want.min_mag_index,
                 got.min_mag_index);
          errors++;
        end
        if (got.max_mag_index !== want.max_mag_index) begin
          $error("max_mag_index: expected %0d, got %0d", want.max_mag_index,
                 got.max_mag_index);
          errors++;
        end
        if (got.average !== want.average) begin
          $error("average: expected %0d, got %0d", $signed(want.average),
                 $signed(got.average));
          errors++;
        end
        if (got.average_valid !== want.average_valid) begin
          $error("average_valid: expected %0d, got %0d", want.average_valid,
                 got.average_valid);
          errors++;
        end
        if (got.first_index !== want.first_index) begin
          $error("first_index: expected %0d, got %0d", want.first_index, got.first_index);
          errors++;
        end
        if (got.first_found !== want.first_found) begin
          $error("first_found: expected %0d, got %0d", want.first_found, got.first_found);
          errors++;
        end
        if (got.last_index !== want.last_index) begin
          $error("last_index: expected %0d, got %0d", want.last_index, got.last_index);
          errors++;
        end
        if (got.last_found !== want.last_found) begin
          $error("last_found: expected %0d, got %0d", want.last_found, got.last_found);
          errors++;
        end
      end
    end
  end

  // Stimulus: directed table, then random series
  initial begin
    row_t rows[$];
    row_t r;
    stats_t single, empty, zero_span;
    logic [31:0] t;
    int len;
    bit broken;

    single = '0;
    single.any_in_window = 1'b1;
    single.average = 16'd7;
    single.average_valid = 1'b1;
    single.first_found = 1'b1;
    single.last_found = 1'b1;
    empty = '0;
    zero_span = single;
    zero_span.average = '0;
    zero_span.average_valid = 1'b0;

    win_start = 32'd0;
    win_stop = 32'hFFFF_FFFF;
    clear_series();

    // One-sample series, then extremes of time and value
    rows.push_back('{ROW_SAMPLE, 2'd0, 32'd5, 16'd7, 1'b1, 1'b1, single});
    rows.push_back('{ROW_SAMPLE, 2'd0, 32'd0, 16'h8000, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_SAMPLE, 2'd0, 32'd10, 16'h7FFF, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_SAMPLE, 2'd0, 32'd10, 16'h0000, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_SAMPLE, 2'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, '0});
    // Inverted window: nothing inside, neither edge found
    rows.push_back('{ROW_WRITE, REG_WINDOW_START, 32'd100, '0, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_WRITE, REG_WINDOW_STOP, 32'd50, '0, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_SAMPLE, 2'd0, 32'd75, 16'd5, 1'b1, 1'b1, empty});
    // Spare indexes are ignored
    rows.push_back('{ROW_WRITE, REG_WINDOW_START, 32'd0, '0, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_WRITE, REG_WINDOW_STOP, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_WRITE, RegSpareA, 32'hDEAD_BEEF, '0, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_WRITE, RegSpareB, 32'h1234_5678, '0, 1'b0, 1'b0, '0});
    // Out-of-order times within one series
    rows.push_back('{ROW_SAMPLE, 2'd0, 32'd100, 16'd300, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_SAMPLE, 2'd0, 32'd50, -16'sd200, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_SAMPLE, 2'd0, 32'd200, -16'sd5, 1'b1, 1'b0, '0});
    // Window moved in the middle of a series
    rows.push_back('{ROW_SAMPLE, 2'd0, 32'd10, 16'd3, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_WRITE, REG_WINDOW_STOP, 32'd20, '0, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_SAMPLE, 2'd0, 32'd30, 16'd4, 1'b1, 1'b0, '0});
    // Window pinned at the top: zero period
    rows.push_back('{ROW_WRITE, REG_WINDOW_START, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_WRITE, REG_WINDOW_STOP, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_SAMPLE, 2'd0, 32'hFFFF_FFFF, 16'h7FFF, 1'b1, 1'b1, zero_span});
    rows.push_back('{ROW_WRITE, REG_WINDOW_START, 32'd0, '0, 1'b0, 1'b0, '0});
    rows.push_back('{ROW_WRITE, REG_WINDOW_STOP, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      r = rows[i];
      if (r.kind == ROW_WRITE) write_reg(r.reg_idx, r.data);
      else send_sample(r.data, r.value, r.last, r.typed, r.result);
    end

    // Random series, mostly well formed, some with scrambled times
    while (n_samples < RandomItems) begin
      if ($urandom_range(0, 3) == 0) rewindow();
      quiet = $urandom_range(0, 5) == 0;
      if ($urandom_range(0, 40) == 0) hold_req = 1'b1;
      len = $urandom_range(1, 12);
      broken = $urandom_range(0, 9) == 0;
      case ($urandom_range(0, 2))
        0: t = win_start - $urandom_range(0, 60);
        1: t = $urandom;
        default: t = win_start + $urandom_range(0, 40);
      endcase
      for (int k = 0; k < len; k++) begin
        if (broken && $urandom_range(0, 2) == 0) t = $urandom;
        else if (k > 0) t = t + $urandom_range(0, 30);
        send_sample(t, pick_value(), k == len - 1);
      end
    end
    quiet = 1'b0;
    hold_req = 1'b1;
    for (int k = 0; k < 6; k++) send_sample($urandom, pick_value(), 1'b1);
    s_axis_tvalid <= 1'b0;

    wait (stats_due.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    $display("Ran %0d samples and %0d register writes; checked %0d statistics records.",
             n_samples, n_writes, n_records);
    $display("Covered window extremes, inverted windows, unordered times and long output stalls.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
